// File: rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared widths, codes, types and the arctangent table for the polygon
// convexity checker.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int COORD_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int EDGE_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * EDGE_W;
  localparam int CP_W         = PROD_W + 1;
  localparam int ANG_W        = 29;
  localparam int TURN_W       = 15;
  localparam int TOTAL_W      = 18;
  localparam int LIMIT_W      = 10;
  localparam int CX_W         = 34;

  localparam logic [LIMIT_W-1:0] TURN_LIMIT_RST = LIMIT_W'(400);

  localparam logic [1:0] FAIL_NONE = 2'd0;
  localparam logic [1:0] FAIL_SIGN = 2'd1;
  localparam logic [1:0] FAIL_TURN = 2'd2;

  localparam logic [1:0] SIGN_NONE = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  localparam logic [2:0] REG_TURN_LIMIT = 3'd0;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    logic                   start;
    logic signed [CP_W-1:0] y;
    logic signed [CP_W-1:0] x;
  } atan_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [TURN_W-1:0] angle;
  } atan_rsp_t;

  // atan(2^-i) in 2^-20 degree
  function automatic logic signed [ANG_W-1:0] atan_tab(input logic [4:0] idx);
    logic signed [ANG_W-1:0] r;
    case (idx)
      5'd0:  r = ANG_W'(47185920);
      5'd1:  r = ANG_W'(27855475);
      5'd2:  r = ANG_W'(14718068);
      5'd3:  r = ANG_W'(7471121);
      5'd4:  r = ANG_W'(3750058);
      5'd5:  r = ANG_W'(1876857);
      5'd6:  r = ANG_W'(938658);
      5'd7:  r = ANG_W'(469357);
      5'd8:  r = ANG_W'(234682);
      5'd9:  r = ANG_W'(117342);
      5'd10: r = ANG_W'(58671);
      5'd11: r = ANG_W'(29335);
      5'd12: r = ANG_W'(14668);
      5'd13: r = ANG_W'(7334);
      5'd14: r = ANG_W'(3667);
      5'd15: r = ANG_W'(1833);
      5'd16: r = ANG_W'(917);
      5'd17: r = ANG_W'(458);
      5'd18: r = ANG_W'(229);
      5'd19: r = ANG_W'(115);
      5'd20: r = ANG_W'(57);
      5'd21: r = ANG_W'(29);
      5'd22: r = ANG_W'(14);
      5'd23: r = ANG_W'(7);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/pcc_if.sv
// ----------------------------------------------------------------------------
// pcc_if
// Valid/ready channels for vertex items and verdict items.
// ----------------------------------------------------------------------------
interface pcc_vtx_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [pcc_pkg::COORD_BITS-1:0] vertex_x;
  logic signed [pcc_pkg::COORD_BITS-1:0] vertex_y;
  logic                                   last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface pcc_res_if;
  logic       valid;
  logic       ready;
  logic       is_convex;
  logic [1:0] fail_cause;
  logic       last_result;

  modport source (output valid, is_convex, fail_cause, last_result, input ready);
  modport sink   (input valid, is_convex, fail_cause, last_result, output ready);
endinterface

// File: rtl/pcc_apb_regs.sv
// ----------------------------------------------------------------------------
// pcc_apb_regs
// APB register file holding the turn limit.
// ----------------------------------------------------------------------------
module pcc_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [pcc_pkg::LIMIT_W-1:0]   turn_limit_o
);
  import pcc_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic               sel_limit;

  assign sel_limit = ({paddr[2], 2'b00} == REG_TURN_LIMIT);
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= TURN_LIMIT_RST;
    end else if (psel && penable && pwrite && sel_limit) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata       = sel_limit ? {{(32-LIMIT_W){1'b0}}, limit_q} : 32'd0;
  assign turn_limit_o = limit_q;

endmodule

// File: rtl/pcc_atan.sv
// ----------------------------------------------------------------------------
// pcc_atan
// Iterative atan2: normalise, CORDIC vectoring, quadrant map and rounding
// to 1/64 degree.
// ----------------------------------------------------------------------------
module pcc_atan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcc_pkg::atan_req_t  req_i,
  output pcc_pkg::atan_rsp_t  rsp_o
);
  import pcc_pkg::*;

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_NORM = 2'd1;
  localparam logic [1:0] A_ROT  = 2'd2;
  localparam logic [1:0] A_FIN  = 2'd3;

  localparam logic signed [ANG_W-1:0] QUARTER = ANG_W'(90 * (2 ** 20));
  localparam logic signed [ANG_W-1:0] FULL    = ANG_W'(180 * (2 ** 20));
  localparam logic signed [ANG_W-1:0] HALF_LSB = ANG_W'(2 ** 13);

  logic [1:0]               state_q;
  logic [CP_W-1:0]          ux_q, uy_q;
  logic                     xneg_q, yneg_q;
  logic signed [CX_W-1:0]   cx_q, cy_q;
  logic signed [ANG_W-1:0]  a_q;
  logic [STEP_W-1:0]        step_q;
  logic                     done_q;
  logic signed [TURN_W-1:0] angle_q;

  logic [CP_W-1:0]          m;
  logic signed [CX_W-1:0]   sh_x, sh_y;
  logic signed [ANG_W-1:0]  a_clamp, v, v_rnd;

  assign m    = (ux_q > uy_q) ? ux_q : uy_q;
  assign sh_x = cx_q >>> step_q;
  assign sh_y = cy_q >>> step_q;

  always_comb begin
    a_clamp = a_q;
    if (a_q < 0) begin
      a_clamp = '0;
    end else if (a_q > QUARTER) begin
      a_clamp = QUARTER;
    end
    v = xneg_q ? (FULL - a_clamp) : a_clamp;
    if (yneg_q) begin
      v = -v;
    end
    v_rnd = v + HALF_LSB;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            state_q <= (req_i.y == '0) ? A_FIN : A_NORM;
          end
        end
        A_NORM: begin
          if (!(|m[CP_W-1:30]) && m[29]) begin
            state_q <= A_ROT;
          end
        end
        A_ROT: begin
          if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
            state_q <= A_FIN;
          end
        end
        A_FIN: begin
          state_q <= A_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      A_IDLE: begin
        ux_q   <= req_i.x[CP_W-1] ? CP_W'(-req_i.x) : CP_W'(req_i.x);
        uy_q   <= req_i.y[CP_W-1] ? CP_W'(-req_i.y) : CP_W'(req_i.y);
        xneg_q <= req_i.x[CP_W-1];
        yneg_q <= req_i.y[CP_W-1];
        a_q    <= '0;
        step_q <= '0;
      end
      A_NORM: begin
        if (|m[CP_W-1:30]) begin
          ux_q <= ux_q >> 1;
          uy_q <= uy_q >> 1;
        end else if (!(|m[CP_W-1:21])) begin
          ux_q <= ux_q << 8;
          uy_q <= uy_q << 8;
        end else if (!m[29]) begin
          ux_q <= ux_q << 1;
          uy_q <= uy_q << 1;
        end
        cx_q <= $signed({{(CX_W-30){1'b0}}, ux_q[29:0]});
        cy_q <= $signed({{(CX_W-30){1'b0}}, uy_q[29:0]});
      end
      A_ROT: begin
        if (!cy_q[CX_W-1]) begin
          cx_q <= cx_q + sh_y;
          cy_q <= cy_q - sh_x;
          a_q  <= a_q + atan_tab(5'(step_q));
        end else begin
          cx_q <= cx_q - sh_y;
          cy_q <= cy_q + sh_x;
          a_q  <= a_q - atan_tab(5'(step_q));
        end
        step_q <= step_q + 1'b1;
      end
      A_FIN: begin
        angle_q <= v_rnd[ANG_W-1:14];
      end
      default: ;
    endcase
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.angle = angle_q;

endmodule

// File: rtl/polygon_convexity_check_unit.sv
// ----------------------------------------------------------------------------
// polygon_convexity_check_unit
// Convexity check over a vertex stream: edge products on one shared
// multiplier, turn angle from an iterative CORDIC, sign and turn checks.
// ----------------------------------------------------------------------------
// A corner goes through load, multiply, start, normalise, 16 CORDIC iterations,
// finish, done and check; normalise and CORDIC are skipped when the cross
// product is zero, and only load is left once the polygon has failed. A vertex
// item with no corner goes through idle and update; the last vertex adds up to
// two wrap corners and an emit step. Ready is high only in idle. Reset (rst_ni
// low, async) clears the polygon state and sets turn_limit to 400.
module polygon_convexity_check_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pcc_vtx_if.sink               vtx_i,
  pcc_res_if.source             res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import pcc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ATAN  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_UPD   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  localparam logic [1:0] C_NEW  = 2'd0;
  localparam logic [1:0] C_WRAP = 2'd1;
  localparam logic [1:0] C_LAST = 2'd2;

  logic [LIMIT_W-1:0] turn_limit;

  logic [2:0]  state_q;
  logic [1:0]  cidx_q;
  logic [2:0]  mcnt_q;
  point_t      in_q, first_q, second_q, older_q, newer_q;
  logic        last_q;
  logic [1:0]  seen_q, ref_sign_q, fail_q;
  logic signed [TOTAL_W-1:0] total_q;
  logic signed [EDGE_W-1:0]  ax_q, ay_q, bx_q, by_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [CP_W-1:0]    cross_q, dot_q;
  logic        res_valid_q, res_convex_q;
  logic [1:0]  res_cause_q;

  point_t      p0, p1, p2;
  logic signed [EDGE_W-1:0] mul_a, mul_b;
  logic signed [TOTAL_W-1:0] tsum, bound;
  logic [1:0]  csign;
  logic [1:0]  seen_inc;
  atan_req_t   atan_req;
  atan_rsp_t   atan_rsp;

  pcc_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .turn_limit_o (turn_limit)
  );

  assign atan_req.start = (state_q == S_ATAN);
  assign atan_req.y     = cross_q;
  assign atan_req.x     = dot_q;

  pcc_atan u_atan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (atan_req),
    .rsp_o  (atan_rsp)
  );

  always_comb begin
    unique case (cidx_q)
      C_NEW:   begin p0 = older_q; p1 = newer_q; p2 = in_q;     end
      C_WRAP:  begin p0 = older_q; p1 = newer_q; p2 = first_q;  end
      default: begin p0 = newer_q; p1 = first_q; p2 = second_q; end
    endcase
  end

  always_comb begin
    case (mcnt_q)
      3'd0:    begin mul_a = ax_q; mul_b = by_q; end
      3'd1:    begin mul_a = ay_q; mul_b = bx_q; end
      3'd2:    begin mul_a = ax_q; mul_b = bx_q; end
      default: begin mul_a = ay_q; mul_b = by_q; end
    endcase
  end

  assign tsum     = total_q + TOTAL_W'(atan_rsp.angle);
  assign bound    = $signed({{(TOTAL_W-LIMIT_W-6){1'b0}}, turn_limit, 6'b0});
  assign csign    = cross_q[CP_W-1] ? SIGN_NEG : SIGN_POS;
  assign seen_inc = (seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1;

  assign vtx_i.ready       = (state_q == S_IDLE);
  assign res_o.valid       = res_valid_q;
  assign res_o.is_convex   = res_convex_q;
  assign res_o.fail_cause  = res_cause_q;
  assign res_o.last_result = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cidx_q       <= C_NEW;
      mcnt_q       <= '0;
      seen_q       <= '0;
      ref_sign_q   <= SIGN_NONE;
      fail_q       <= FAIL_NONE;
      total_q      <= '0;
      res_valid_q  <= 1'b0;
      res_convex_q <= 1'b0;
      res_cause_q  <= FAIL_NONE;
      first_q      <= '0;
      second_q     <= '0;
      older_q      <= '0;
      newer_q      <= '0;
    end else begin
      if (res_valid_q && res_o.ready && state_q != S_EMIT) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (vtx_i.valid) begin
            cidx_q  <= C_NEW;
            state_q <= (seen_q >= 2'd2) ? S_LOAD : S_UPD;
          end
        end
        S_LOAD: begin
          mcnt_q <= '0;
          if (fail_q != FAIL_NONE) begin
            unique case (cidx_q)
              C_NEW:   state_q <= S_UPD;
              C_WRAP:  begin cidx_q <= C_LAST; state_q <= S_LOAD; end
              default: state_q <= S_EMIT;
            endcase
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          mcnt_q <= mcnt_q + 3'd1;
          if (mcnt_q == 3'd4) begin
            state_q <= S_ATAN;
          end
        end
        S_ATAN: state_q <= S_WAIT;
        S_WAIT: begin
          if (atan_rsp.done) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          total_q <= tsum;
          if (tsum > bound || tsum < -bound) begin
            fail_q <= FAIL_TURN;
          end else if (cross_q != '0) begin
            if (ref_sign_q != SIGN_NONE && ref_sign_q != csign) begin
              fail_q <= FAIL_SIGN;
            end else begin
              ref_sign_q <= csign;
            end
          end
          unique case (cidx_q)
            C_NEW:   state_q <= S_UPD;
            C_WRAP:  begin cidx_q <= C_LAST; state_q <= S_LOAD; end
            default: state_q <= S_EMIT;
          endcase
        end
        S_UPD: begin
          if (seen_q == 2'd0) begin
            first_q <= in_q;
          end else if (seen_q == 2'd1) begin
            second_q <= in_q;
          end
          older_q <= newer_q;
          newer_q <= in_q;
          seen_q  <= seen_inc;
          if (last_q && seen_inc == 2'd3) begin
            cidx_q  <= C_WRAP;
            state_q <= S_LOAD;
          end else if (last_q) begin
            state_q <= S_EMIT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!res_valid_q || res_o.ready) begin
            res_valid_q  <= 1'b1;
            res_convex_q <= (fail_q == FAIL_NONE);
            res_cause_q  <= fail_q;
            seen_q       <= '0;
            ref_sign_q   <= SIGN_NONE;
            total_q      <= '0;
            fail_q       <= FAIL_NONE;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && vtx_i.valid) begin
      in_q.x <= vtx_i.vertex_x;
      in_q.y <= vtx_i.vertex_y;
      last_q <= vtx_i.last_vertex;
    end
    if (state_q == S_LOAD) begin
      ax_q <= EDGE_W'(p1.x) - EDGE_W'(p0.x);
      ay_q <= EDGE_W'(p1.y) - EDGE_W'(p0.y);
      bx_q <= EDGE_W'(p2.x) - EDGE_W'(p1.x);
      by_q <= EDGE_W'(p2.y) - EDGE_W'(p1.y);
    end
    if (state_q == S_MUL) begin
      prod_q <= mul_a * mul_b;
      case (mcnt_q)
        3'd1: cross_q <= CP_W'(prod_q);
        3'd2: cross_q <= cross_q - CP_W'(prod_q);
        3'd3: dot_q   <= CP_W'(prod_q);
        3'd4: dot_q   <= dot_q + CP_W'(prod_q);
        default: ;
      endcase
    end
  end

endmodule

// File: verif/tb_polygon_convexity_check_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polygon_convexity_check_unit
// Drives vertex streams into the convexity checker and compares every
// verdict item with a local bit-true model of the sign and turn checks.
// ----------------------------------------------------------------------------
module tb_polygon_convexity_check_unit;
  import pcc_pkg::*;

  typedef struct {
    logic       is_convex;
    logic [1:0] fail_cause;
    logic       last_result;
  } verdict_t;

  typedef struct {
    longint x;
    longint y;
  } pt_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pcc_vtx_if vtx ();
  pcc_res_if res ();

  polygon_convexity_check_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .vtx_i(vtx.sink), .res_o(res.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk_i = ~clk_i;

  // model state
  longint   limit_deg;
  pt_t      p_first, p_second, p_older, p_newer;
  int       n_seen;
  logic [1:0] ref_sgn;
  longint   turn_sum;
  logic [1:0] fail_st;
  verdict_t verdicts_due[$];
  int       errors = 0;
  int       n_items = 0;
  int       n_verdicts = 0;
  int       n_nonconvex = 0;
  bit       rx_hold = 1'b0;
  bit       long_gaps = 1'b1;

  initial begin
    vtx.valid = 1'b0;
    vtx.vertex_x = '0;
    vtx.vertex_y = '0;
    vtx.last_vertex = 1'b0;
    res.ready = 1'b0;
  end

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_turn(longint y, longint x);
    longint ux, uy, m, a, cx, cy, nx, ny, v;
    longint tab[16] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
      938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833};
    longint fullv, quarter;
    fullv = 180 * 64'sd1048576;
    quarter = 90 * 64'sd1048576;
    ux = x < 0 ? -x : x;
    uy = y < 0 ? -y : y;
    a = 0;
    if (uy != 0) begin
      m = ux > uy ? ux : uy;
      while (m >= (64'sd1 << 30)) begin
        m = m >> 1; ux = ux >> 1; uy = uy >> 1;
      end
      while (m < (64'sd1 << 29)) begin
        m = m << 1; ux = ux << 1; uy = uy << 1;
      end
      cx = ux;
      cy = uy;
      for (int i = 0; i < CORDIC_STEPS && i < 16; i++) begin
        if (cy >= 0) begin
          nx = cx + shr(cy, i); ny = cy - shr(cx, i); a += tab[i];
        end else begin
          nx = cx - shr(cy, i); ny = cy + shr(cx, i); a -= tab[i];
        end
        cx = nx;
        cy = ny;
      end
      if (a < 0) a = 0;
      if (a > quarter) a = quarter;
    end
    if (x >= 0) v = (y < 0) ? -a : a;
    else v = (y < 0) ? -(fullv - a) : (fullv - a);
    return shr(v + 8192, 14);
  endfunction

  task automatic eval_corner(pt_t p0, pt_t p1, pt_t p2);
    longint ax, ay, bx, by, cr, dt, bound;
    logic [1:0] s;
    ax = p1.x - p0.x; ay = p1.y - p0.y;
    bx = p2.x - p1.x; by = p2.y - p1.y;
    cr = ax * by - ay * bx;
    dt = ax * bx + ay * by;
    bound = limit_deg * 64;
    if (fail_st != FAIL_NONE) return;
    turn_sum += atan_turn(cr, dt);
    if (turn_sum > bound || turn_sum < -bound) begin
      fail_st = FAIL_TURN;
      return;
    end
    if (cr == 0) return;
    s = cr > 0 ? SIGN_POS : SIGN_NEG;
    if (ref_sgn != SIGN_NONE && ref_sgn != s) begin
      fail_st = FAIL_SIGN;
      return;
    end
    ref_sgn = s;
  endtask

  task automatic model_vertex(logic signed [15:0] x, logic signed [15:0] y, logic lst);
    pt_t p;
    verdict_t v;
    p.x = x;
    p.y = y;
    if (n_seen >= 2) eval_corner(p_older, p_newer, p);
    if (n_seen == 0) p_first = p;
    else if (n_seen == 1) p_second = p;
    p_older = p_newer;
    p_newer = p;
    if (n_seen < 3) n_seen++;
    if (!lst) return;
    if (n_seen >= 3) begin
      eval_corner(p_older, p_newer, p_first);
      eval_corner(p_newer, p_first, p_second);
    end
    v.is_convex = (fail_st == FAIL_NONE);
    v.fail_cause = fail_st;
    v.last_result = 1'b1;
    verdicts_due.push_back(v);
    n_seen = 0;
    ref_sgn = SIGN_NONE;
    turn_sum = 0;
    fail_st = FAIL_NONE;
  endtask

  function automatic int gap_len();
    if (long_gaps && $urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // ready is low after each accept, so the extra idle edge before valid costs nothing
  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, logic lst);
    repeat (gap_len() + 1) @(posedge clk_i);
    vtx.valid <= 1'b1;
    vtx.vertex_x <= x;
    vtx.vertex_y <= y;
    vtx.last_vertex <= lst;
    @(posedge clk_i);
    while (!vtx.ready) @(posedge clk_i);
    model_vertex(x, y, lst);
    n_items++;
    vtx.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [9:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 3'(REG_TURN_LIMIT * 4);
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    limit_deg = val;
  endtask

  // verdict checker and receiver stalls
  always @(posedge clk_i) begin
    if (res.valid && res.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict item with none expected");
        errors++;
      end else begin
        verdict_t e;
        e = verdicts_due.pop_front();
        n_verdicts++;
        if (!e.is_convex) n_nonconvex++;
        if (res.is_convex !== e.is_convex) begin
          $error("is_convex exp %0d got %0d", e.is_convex, res.is_convex); errors++;
        end
        if (res.fail_cause !== e.fail_cause) begin
          $error("fail_cause exp %0d got %0d", e.fail_cause, res.fail_cause); errors++;
        end
        if (res.last_result !== e.last_result) begin
          $error("last_result exp %0d got %0d", e.last_result, res.last_result); errors++;
        end
      end
    end
  end

  initial begin
    int k;
    forever begin
      @(posedge clk_i);
      if (rx_hold) res.ready <= 1'b0;
      else if (!long_gaps) res.ready <= 1'b1;
      else begin
        k = gap_len();
        if (k == 0) res.ready <= 1'b1;
        else begin
          res.ready <= 1'b0;
          repeat (k - 1) @(posedge clk_i);
        end
      end
    end
  end

  function automatic logic signed [15:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 40)) - 20);
      2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task automatic send_poly(int n, longint cx, longint cy, longint r, bit rev);
    real a, step;
    logic signed [15:0] x, y;
    step = 6.2831853 / n;
    a = $urandom_range(0, 628) / 100.0;
    for (int i = 0; i < n; i++) begin
      x = 16'(cx + longint'(r * $cos(a)));
      y = 16'(cy + longint'(r * (rev ? -$sin(a) : $sin(a))));
      send_vertex(x, y, i == n - 1);
      a += step;
    end
  endtask

  task automatic test_directed();
    send_vertex(0, 0, 1);
    send_vertex(5, 5, 0); send_vertex(6, 6, 1);
    send_vertex(0, 0, 0); send_vertex(100, 0, 0); send_vertex(0, 100, 1);
    send_vertex(0, 0, 0); send_vertex(0, 100, 0); send_vertex(100, 0, 1);
    send_vertex(0, 0, 0); send_vertex(10, 0, 0); send_vertex(20, 0, 1);
    send_vertex(0, 0, 0); send_vertex(10, 0, 0); send_vertex(0, 0, 1);
    send_vertex(0, 0, 0); send_vertex(0, 0, 0); send_vertex(0, 0, 1);
    send_vertex(16'sh8000, 16'sh8000, 0); send_vertex(16'sh7FFF, 16'sh8000, 0);
    send_vertex(16'sh7FFF, 16'sh7FFF, 0); send_vertex(16'sh8000, 16'sh7FFF, 1);
    wait_drain();
  endtask

  task automatic test_limits();
    logic [9:0] lims[4] = '{10'd0, 10'd359, 10'd1023, 10'd181};
    foreach (lims[i]) begin
      write_limit(lims[i]);
      send_poly(4, 0, 0, 1000, 0);
      send_poly(5, 100, -50, 3000, 1);
      wait_drain();
    end
    write_limit(10'd400);
  endtask

  task automatic test_random(int count);
    int n;
    while (count > 0) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) send_vertex(rnd_coord(), rnd_coord(), i == n - 1);
        end
        2: begin
          n = 1;
          send_vertex(rnd_coord(), rnd_coord(), 1'($urandom_range(0, 1)));
        end
        default: begin
          n = $urandom_range(3, 9);
          send_poly(n, $signed($urandom_range(0, 20000)) - 10000,
                    $signed($urandom_range(0, 20000)) - 10000,
                    $urandom_range(20, 9000), $urandom_range(0, 1));
        end
      endcase
      count -= n;
      if ($urandom_range(0, 40) == 0) begin
        wait_drain();
        write_limit(10'($urandom_range(0, 1023)));
      end
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_poly(3, 0, 0, 500, i[0]);
    join
    wait_drain();
    long_gaps = 1'b0;
    test_random(150);
    long_gaps = 1'b1;
  endtask

  initial begin
    n_seen = 0; ref_sgn = SIGN_NONE; turn_sum = 0; fail_st = FAIL_NONE;
    limit_deg = 400;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limits();
    test_backpressure();
    write_limit(10'd1023);
    test_random(700);
    write_limit(10'd400);
    test_random(800);
    wait_drain();
    $display("covered %0d vertex items, %0d verdicts (%0d not convex)",
             n_items, n_verdicts, n_nonconvex);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end

endmodule
